// ----- sv/kcwd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcwd_pkg: shared types and constants of the key chord window detector
// Widths, register indexes, result codes and chord helper functions.
// ----------------------------------------------------------------------------
package kcwd_pkg;

   localparam int MaxKeys    = 5;               // codes per chord
   localparam int HeldDepth  = 2 * MaxKeys;     // entries of the held set
   localparam int CodeW      = 10;              // width of one chord key code
   localparam int ChordSlots = 5;               // code slots in a chord register
   localparam int CodesW     = CodeW * ChordSlots;
   localparam int LenW       = 3;
   localparam int WinW       = 16;
   localparam int TimeW      = 32;
   localparam int EventW     = 16;
   localparam int FillW      = $clog2(HeldDepth + 1);
   localparam int HitW       = 2;
   localparam int CountW     = 4;
   localparam int QueueDepth = 2;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = CodesW;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrChordOneCodes = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrChordOneLen   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrChordTwoCodes = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrChordTwoLen   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrWindowMs      = 3'd4;

   // reset values of the registers
   localparam logic [CodesW-1:0] ChordOneReset = CodesW'(64'd326424892);
   localparam logic [CodesW-1:0] ChordTwoReset = CodesW'(64'd328524092);
   localparam logic [LenW-1:0]   LenReset      = 3'd3;
   localparam logic [WinW-1:0]   WindowReset   = 16'd200;

   // result codes
   localparam logic [HitW-1:0] HitNone = 2'd0;
   localparam logic [HitW-1:0] HitOne  = 2'd1;
   localparam logic [HitW-1:0] HitTwo  = 2'd2;

   typedef struct packed {
      logic [CodesW-1:0] one_codes;
      logic [LenW-1:0]   one_len;
      logic [CodesW-1:0] two_codes;
      logic [LenW-1:0]   two_len;
      logic [WinW-1:0]   window_ms;
   } cfg_type;

   // classified key event, front to back
   typedef struct packed {
      logic [CodeW-1:0] code;
      logic             code_ok;   // valid pressed code that belongs to a chord
      logic [TimeW-1:0] time_ms;
      logic             batch_first;
      logic             batch_last;
   } item_type;

   function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
      return (len > LenW'(MaxKeys)) ? LenW'(MaxKeys) : len;
   endfunction

   // entries past the register's slots read as zero
   function automatic logic [CodeW-1:0] chord_entry(input logic [CodesW-1:0] codes,
                                                    input int idx);
      return CodeW'(codes >> (CodeW * idx));
   endfunction

   function automatic logic chord_has(input logic [CodesW-1:0] codes,
                                      input logic [LenW-1:0]   len,
                                      input logic [CodeW-1:0]  code);
      logic found;
      found = 1'b0;
      for (int i = 0; i < MaxKeys; i++) begin
         if (LenW'(i) < eff_len(len) && chord_entry(codes, i) == code) begin
            found = 1'b1;
         end
      end
      return found;
   endfunction

endpackage
`default_nettype wire

// ----- sv/kcwd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcwd_front: request intake and classification
// Registers each accepted key event with its chord membership decoded.
// ----------------------------------------------------------------------------
module kcwd_front import kcwd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [EventW-1:0] req_event_code,
   input  wire logic              req_key_down,
   input  wire logic [TimeW-1:0]  req_time_ms,
   input  wire logic              req_batch_first,
   input  wire logic              req_batch_last,
   output logic                   q_push,
   output item_type               q_item,
   input  wire logic              q_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;
   logic     narrow_ok;
   logic [CodeW-1:0] code10;

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_item   = item_ff;

   always_comb begin
      code10    = req_event_code[CodeW-1:0];
      narrow_ok = (req_event_code[EventW-1:CodeW] == '0) && (code10 != '0);
      item_in.code        = code10;
      item_in.code_ok     = narrow_ok && req_key_down &&
                            (chord_has(cfg.one_codes, cfg.one_len, code10) ||
                             chord_has(cfg.two_codes, cfg.two_len, code10));
      item_in.time_ms     = req_time_ms;
      item_in.batch_first = req_batch_first;
      item_in.batch_last  = req_batch_last;
      valid_in = take || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/kcwd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcwd_queue: short queue between front and back
// Holds classified events so that front and back stall independently.
// ----------------------------------------------------------------------------
module kcwd_queue import kcwd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      head,
   output logic          empty
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type            mem [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- sv/kcwd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcwd_back: window, held set and chord check
// Unless stalled, applies one event per cycle and registers the response.
// ----------------------------------------------------------------------------
module kcwd_back import kcwd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire item_type          head,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [HitW-1:0]        rsp_chord_hit,
   output logic [CountW-1:0]      rsp_held_count
);

   logic [CodeW-1:0] held_ff [HeldDepth];
   logic [FillW-1:0] fill_ff, fill_in;
   logic             timer_ff, timer_in;
   logic [TimeW-1:0] start_ff, start_in;
   logic             frozen_ff, frozen_in;
   logic             out_valid_ff, out_valid_in;
   logic [HitW-1:0]  hit_ff, hit_in;
   logic [FillW-1:0] count_ff;

   logic             step;
   logic             clr;
   logic [FillW-1:0] f_fill;
   logic             f_timer, f_frozen;
   logic [TimeW-1:0] f_start;
   logic             act;
   logic             already;
   logic             add;
   logic             one_done, two_done;
   logic [CodeW-1:0] entry_one, entry_two;
   logic             seen_one, seen_two;
   logic [LenW-1:0]  len1, len2;

   assign step      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = step;
   assign rsp_empty = !out_valid_ff;
   assign rsp_chord_hit  = hit_ff;
   assign rsp_held_count = CountW'(count_ff);

   always_comb begin
      // expiry, or clear after a hit, on batch start
      clr = head.batch_first &&
            (frozen_ff || (timer_ff && ((head.time_ms - start_ff) > TimeW'(cfg.window_ms))));
      f_fill   = clr ? '0 : fill_ff;
      f_timer  = clr ? 1'b0 : timer_ff;
      f_start  = clr ? '0 : start_ff;
      f_frozen = clr ? 1'b0 : frozen_ff;

      // add the pressed code
      act      = head.code_ok && !f_frozen;
      timer_in = f_timer || act;
      start_in = (act && !f_timer) ? head.time_ms : f_start;
      already  = 1'b0;
      for (int j = 0; j < HeldDepth; j++) begin
         if (FillW'(j) < f_fill && held_ff[j] == head.code) begin
            already = 1'b1;
         end
      end
      add = act && ((head.time_ms - start_in) < TimeW'(cfg.window_ms)) && !already &&
            (f_fill < FillW'(HeldDepth));
      fill_in = f_fill + FillW'(add);

      // chord check against the updated set: every used entry nonzero and held
      len1 = eff_len(cfg.one_len);
      len2 = eff_len(cfg.two_len);
      one_done = (len1 != '0);
      two_done = (len2 != '0);
      for (int i = 0; i < MaxKeys; i++) begin
         entry_one = chord_entry(cfg.one_codes, i);
         entry_two = chord_entry(cfg.two_codes, i);
         seen_one  = add && (head.code == entry_one);
         seen_two  = add && (head.code == entry_two);
         for (int j = 0; j < HeldDepth; j++) begin
            if (FillW'(j) < f_fill && held_ff[j] == entry_one) begin
               seen_one = 1'b1;
            end
            if (FillW'(j) < f_fill && held_ff[j] == entry_two) begin
               seen_two = 1'b1;
            end
         end
         if (LenW'(i) < len1 && (entry_one == '0 || !seen_one)) begin
            one_done = 1'b0;
         end
         if (LenW'(i) < len2 && (entry_two == '0 || !seen_two)) begin
            two_done = 1'b0;
         end
      end

      priority if (head.batch_last && one_done) begin
         hit_in = HitOne;
      end else if (head.batch_last && two_done) begin
         hit_in = HitTwo;
      end else begin
         hit_in = HitNone;
      end
      frozen_in    = f_frozen || (hit_in != HitNone);
      out_valid_in = step || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         timer_ff     <= 1'b0;
         start_ff     <= '0;
         frozen_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            fill_ff   <= fill_in;
            timer_ff  <= timer_in;
            start_ff  <= start_in;
            frozen_ff <= frozen_in;
         end
      end
      if (step) begin
         hit_ff   <= hit_in;
         count_ff <= fill_in;
         if (add) begin
            held_ff[f_fill[$clog2(HeldDepth)-1:0]] <= head.code;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/key_chord_window_detector_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// key_chord_window_detector_core: two-chord key press detector
// Tracks distinct chord keys pressed inside a time window and reports a chord
// hit on the last event of each batch.
//
//   channel   ports                       handshake
//   request   req_* (event, time, marks)  accepted on push & !full
//   response  rsp_chord_hit, held_count   accepted on pop & !empty
//   config    csr_write_en/index/wdata    written on csr_write_en
//
// One request per cycle sustained while responses are popped; a response passes
// the front register, the queue and the back step into the output register,
// behind any older requests the queue holds.
// The back's combinational update of the held set against all ten stored
// codes sets the rate.
// Synchronous active-high reset empties the pipeline, the held set and the
// window timer and loads the register defaults.
// A stalled response holds the back; the two-entry queue and front register
// absorb requests until full rises.
// ----------------------------------------------------------------------------
module key_chord_window_detector_core import kcwd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [EventW-1:0]   req_event_code,
   input  wire logic                req_key_down,
   input  wire logic [TimeW-1:0]    req_time_ms,
   input  wire logic                req_batch_first,
   input  wire logic                req_batch_last,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [HitW-1:0]          rsp_chord_hit,
   output logic [CountW-1:0]        rsp_held_count
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_push, q_full, q_pop, q_empty;
   item_type q_in_item, q_head;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CsrChordOneCodes: cfg_in.one_codes = csr_wdata[CodesW-1:0];
            CsrChordOneLen:   cfg_in.one_len   = csr_wdata[LenW-1:0];
            CsrChordTwoCodes: cfg_in.two_codes = csr_wdata[CodesW-1:0];
            CsrChordTwoLen:   cfg_in.two_len   = csr_wdata[LenW-1:0];
            CsrWindowMs:      cfg_in.window_ms = csr_wdata[WinW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_codes <= ChordOneReset;
         cfg_ff.one_len   <= LenReset;
         cfg_ff.two_codes <= ChordTwoReset;
         cfg_ff.two_len   <= LenReset;
         cfg_ff.window_ms <= WindowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify requests
   kcwd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_event_code  (req_event_code),
      .req_key_down    (req_key_down),
      .req_time_ms     (req_time_ms),
      .req_batch_first (req_batch_first),
      .req_batch_last  (req_batch_last),
      .q_push          (q_push),
      .q_item          (q_in_item),
      .q_full          (q_full)
   );

   // decouple front and back
   kcwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // update the held set and check chords
   kcwd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_chord_hit  (rsp_chord_hit),
      .rsp_held_count (rsp_held_count)
   );

endmodule
`default_nettype wire
